// File: rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the battery charge controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;
	localparam int LEVEL_W    = 12;

	localparam logic [2:0] REG_UNPLUG    = 3'd0;
	localparam logic [2:0] REG_PLUG      = 3'd1;
	localparam logic [2:0] REG_RECHARGE  = 3'd2;
	localparam logic [2:0] REG_STOP      = 3'd3;
	localparam logic [2:0] REG_SLOW_FULL = 3'd4;
	localparam logic [2:0] REG_FAST_FULL = 3'd5;
	localparam logic [2:0] REG_MID       = 3'd6;
	localparam logic [2:0] REG_LOW       = 3'd7;

	localparam logic [LEVEL_W-1:0] RST_UNPLUG    = 12'd1300;
	localparam logic [LEVEL_W-1:0] RST_PLUG      = 12'd1700;
	localparam logic [LEVEL_W-1:0] RST_RECHARGE  = 12'd1214;
	localparam logic [LEVEL_W-1:0] RST_STOP      = 12'd1184;
	localparam logic [LEVEL_W-1:0] RST_SLOW_FULL = 12'd1199;
	localparam logic [LEVEL_W-1:0] RST_FAST_FULL = 12'd1170;
	localparam logic [LEVEL_W-1:0] RST_MID       = 12'd1229;
	localparam logic [LEVEL_W-1:0] RST_LOW       = 12'd1446;

	localparam logic [5:0]  UNPLUG_TICKS     = 6'd50;
	localparam logic [3:0]  PLUG_TICKS       = 4'd10;
	localparam logic [17:0] SLOW_FULL_TICKS  = 18'd180000;
	localparam logic [7:0]  FAST_FULL_TICKS  = 8'd100;
	localparam logic [23:0] FORCE_FULL_TICKS = 24'd5400000;
	localparam logic [23:0] CUTOFF_TICKS     = 24'd8640000;

	localparam logic [12:0] LOWEST_START = 13'd4096;

	localparam logic [1:0] DRIVE_RELEASED = 2'd0;
	localparam logic [1:0] DRIVE_STOPPED  = 2'd1;
	localparam logic [1:0] DRIVE_PWM      = 2'd2;

	localparam logic [1:0] EV_NONE      = 2'd0;
	localparam logic [1:0] EV_POWER_OFF = 2'd1;
	localparam logic [1:0] EV_CHARGE_ON = 2'd2;

	localparam logic [7:0] DUTY_LOW  = 8'd60;
	localparam logic [7:0] DUTY_HIGH = 8'd80;

	typedef struct packed {
		logic [LEVEL_W-1:0] charger_sample;
		logic [LEVEL_W-1:0] battery_sample;
	} sample_t;

	typedef struct packed {
		logic       charging;
		logic       full_res;
		logic [1:0] drive;
		logic [7:0] duty;
		logic [1:0] work_event;
		logic       leds_off;
	} result_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] unplug_level;
		logic [LEVEL_W-1:0] plug_level;
		logic [LEVEL_W-1:0] recharge_level;
		logic [LEVEL_W-1:0] stop_level;
		logic [LEVEL_W-1:0] slow_full_level;
		logic [LEVEL_W-1:0] fast_full_level;
		logic [LEVEL_W-1:0] mid_level;
		logic [LEVEL_W-1:0] low_level;
	} cfg_t;

endpackage

`default_nettype wire

// File: rtl/battery_charge_controller.sv
// ----------------------------------------------------------------------------
// battery_charge_controller
// Charger plug detection, charge termination and PWM drive, one word per tick.
//
// Channel    Direction  Handshake                        Word
// sample     in         sample_valid / sample_stall      sample_t
// result     out        result_valid / result_stall      result_t
// config     in         psel / penable / pwrite / pready 12-bit levels
//
// A sample word is registered on acceptance, and its result is registered in
// the output register when the word advances. One word is taken per cycle while
// the output is not stalled, set by the single pass through the charge-state logic.
// Reset clears all charge state and loads the default levels.
// A stalled result holds the output register, and a full input register then
// raises sample_stall until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module battery_charge_controller
	import bcc_pkg::*;
#(
	parameter logic [5:0]  UNPLUG_TICKS     = bcc_pkg::UNPLUG_TICKS,
	parameter logic [3:0]  PLUG_TICKS       = bcc_pkg::PLUG_TICKS,
	parameter logic [17:0] SLOW_FULL_TICKS  = bcc_pkg::SLOW_FULL_TICKS,
	parameter logic [7:0]  FAST_FULL_TICKS  = bcc_pkg::FAST_FULL_TICKS,
	parameter logic [23:0] FORCE_FULL_TICKS = bcc_pkg::FORCE_FULL_TICKS,
	parameter logic [23:0] CUTOFF_TICKS     = bcc_pkg::CUTOFF_TICKS
)
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  sample_valid,
	output logic                       sample_stall,
	input  sample_t                    sample,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	cfg_t    cfg;
	sample_t sample_s1;
	logic    valid_s1;
	result_t res;
	result_t result_q;
	logic    result_valid_q;
	logic    adv;
	logic    accept;

	bcc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	bcc_core #(
		.UNPLUG_TICKS     (UNPLUG_TICKS),
		.PLUG_TICKS       (PLUG_TICKS),
		.SLOW_FULL_TICKS  (SLOW_FULL_TICKS),
		.FAST_FULL_TICKS  (FAST_FULL_TICKS),
		.FORCE_FULL_TICKS (FORCE_FULL_TICKS),
		.CUTOFF_TICKS     (CUTOFF_TICKS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.smp    (sample_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign adv          = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !adv;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign pready       = 1'b1;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && result_valid_q && result_stall))
		else $error("sample stall raised while a stage is free");

	a_poweroff_leds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.work_event == EV_POWER_OFF) |-> result.leds_off)
		else $error("power-off event without LEDs switched off");

	a_start_charging: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.work_event == EV_CHARGE_ON) |-> result.charging)
		else $error("charging event while not charging");

	a_full_needs_charging: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.charging) |-> !result.full_res)
		else $error("full reported while not charging");
`endif

endmodule

`default_nettype wire

// File: rtl/bcc_regs.sv
// ----------------------------------------------------------------------------
// bcc_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_regs
	import bcc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output cfg_t                       cfg
);

	cfg_t               cfg_q;
	logic [2:0]         idx;
	logic               wr_en;
	logic [LEVEL_W-1:0] wdata;
	logic [LEVEL_W-1:0] rdata;

	assign idx   = paddr[4:2];
	assign wr_en = psel && penable && pwrite;
	assign wdata = pwdata[LEVEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unplug_level    <= RST_UNPLUG;
			cfg_q.plug_level      <= RST_PLUG;
			cfg_q.recharge_level  <= RST_RECHARGE;
			cfg_q.stop_level      <= RST_STOP;
			cfg_q.slow_full_level <= RST_SLOW_FULL;
			cfg_q.fast_full_level <= RST_FAST_FULL;
			cfg_q.mid_level       <= RST_MID;
			cfg_q.low_level       <= RST_LOW;
		end else if (wr_en) begin
			case (idx)
				REG_UNPLUG:    cfg_q.unplug_level    <= wdata;
				REG_PLUG:      cfg_q.plug_level      <= wdata;
				REG_RECHARGE:  cfg_q.recharge_level  <= wdata;
				REG_STOP:      cfg_q.stop_level      <= wdata;
				REG_SLOW_FULL: cfg_q.slow_full_level <= wdata;
				REG_FAST_FULL: cfg_q.fast_full_level <= wdata;
				REG_MID:       cfg_q.mid_level       <= wdata;
				REG_LOW:       cfg_q.low_level       <= wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_UNPLUG:    rdata = cfg_q.unplug_level;
			REG_PLUG:      rdata = cfg_q.plug_level;
			REG_RECHARGE:  rdata = cfg_q.recharge_level;
			REG_STOP:      rdata = cfg_q.stop_level;
			REG_SLOW_FULL: rdata = cfg_q.slow_full_level;
			REG_FAST_FULL: rdata = cfg_q.fast_full_level;
			REG_MID:       rdata = cfg_q.mid_level;
			REG_LOW:       rdata = cfg_q.low_level;
			default:       rdata = '0;
		endcase
	end

	assign prdata = {{(CFG_DATA_W-LEVEL_W){1'b0}}, rdata};
	assign cfg    = cfg_q;

endmodule

`default_nettype wire

// File: rtl/bcc_core.sv
// ----------------------------------------------------------------------------
// bcc_core
// Plug and unplug debounce, charge state and PWM control for one tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_core
	import bcc_pkg::*;
#(
	parameter logic [5:0]  UNPLUG_TICKS     = bcc_pkg::UNPLUG_TICKS,
	parameter logic [3:0]  PLUG_TICKS       = bcc_pkg::PLUG_TICKS,
	parameter logic [17:0] SLOW_FULL_TICKS  = bcc_pkg::SLOW_FULL_TICKS,
	parameter logic [7:0]  FAST_FULL_TICKS  = bcc_pkg::FAST_FULL_TICKS,
	parameter logic [23:0] FORCE_FULL_TICKS = bcc_pkg::FORCE_FULL_TICKS,
	parameter logic [23:0] CUTOFF_TICKS     = bcc_pkg::CUTOFF_TICKS
)
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  sample_t   smp,
	input  cfg_t      cfg,
	output result_t   res
);

	logic [5:0]  unplug_cnt_q, unplug_cnt_d;
	logic [3:0]  plug_cnt_q, plug_cnt_d;
	logic        unplug_done_q, unplug_done_d;
	logic        plug_done_q, plug_done_d;
	logic        charging_q, charging_d;
	logic        full_q, full_d;
	logic        forced_q, forced_d;
	logic        cutoff_q, cutoff_d;
	logic [17:0] slow_cnt_q, slow_cnt_d;
	logic [7:0]  fast_cnt_q, fast_cnt_d;
	logic [23:0] elapsed_q, elapsed_d;
	logic [12:0] lowest_q, lowest_d;
	logic [1:0]  drive_q, drive_d;
	logic [7:0]  duty_q, duty_d;
	logic [1:0]  event_d;
	logic        leds_d;
	logic [11:0] chg;
	logic [11:0] bat;

	assign chg = smp.charger_sample;
	assign bat = smp.battery_sample;

	always_comb begin
		unplug_cnt_d  = unplug_cnt_q;
		plug_cnt_d    = plug_cnt_q;
		unplug_done_d = unplug_done_q;
		plug_done_d   = plug_done_q;
		charging_d    = charging_q;
		full_d        = full_q;
		forced_d      = forced_q;
		cutoff_d      = cutoff_q;
		slow_cnt_d    = slow_cnt_q;
		fast_cnt_d    = fast_cnt_q;
		elapsed_d     = elapsed_q;
		lowest_d      = lowest_q;
		drive_d       = drive_q;
		duty_d        = duty_q;
		event_d       = EV_NONE;
		leds_d        = 1'b0;

		if (chg < cfg.unplug_level) begin
			if (!unplug_done_q) begin
				unplug_cnt_d = unplug_cnt_q + 6'd1;
				if (unplug_cnt_d >= UNPLUG_TICKS) begin
					unplug_done_d = 1'b1;
					plug_done_d   = 1'b0;
					unplug_cnt_d  = '0;
					charging_d    = 1'b0;
					full_d        = 1'b0;
					leds_d        = 1'b1;
					drive_d       = DRIVE_RELEASED;
					event_d       = EV_POWER_OFF;
				end
			end
		end else begin
			unplug_cnt_d = '0;
		end

		if (chg > cfg.plug_level) begin
			if (!plug_done_d) begin
				if (plug_cnt_q <= PLUG_TICKS) begin
					plug_cnt_d = plug_cnt_q + 4'd1;
				end else begin
					unplug_done_d = 1'b0;
					plug_done_d   = 1'b1;
					plug_cnt_d    = '0;
					charging_d    = 1'b1;
					full_d        = 1'b0;
					lowest_d      = LOWEST_START;
					event_d       = EV_CHARGE_ON;
				end
			end
		end else begin
			plug_cnt_d = '0;
		end

		if (charging_d) begin
			if (full_d || forced_q) begin
				if (elapsed_q <= CUTOFF_TICKS) begin
					if (elapsed_q != '1) begin
						elapsed_d = elapsed_q + 24'd1;
					end
				end else begin
					cutoff_d = 1'b1;
				end
				if (cutoff_d || forced_q) begin
					drive_d = DRIVE_STOPPED;
				end else if (bat > cfg.recharge_level) begin
					drive_d = DRIVE_PWM;
					duty_d  = DUTY_LOW;
				end else if (bat <= cfg.stop_level) begin
					drive_d = DRIVE_STOPPED;
				end
			end else begin
				if (bat <= cfg.slow_full_level) begin
					if (slow_cnt_q != '1) begin
						slow_cnt_d = slow_cnt_q + 18'd1;
					end
					if (slow_cnt_d >= SLOW_FULL_TICKS) begin
						full_d = 1'b1;
					end
				end
				if (bat <= cfg.fast_full_level) begin
					if (fast_cnt_q != '1) begin
						fast_cnt_d = fast_cnt_q + 8'd1;
					end
					if (fast_cnt_d >= FAST_FULL_TICKS) begin
						full_d = 1'b1;
					end
				end else begin
					fast_cnt_d = '0;
				end
				if (elapsed_q <= FORCE_FULL_TICKS) begin
					if (elapsed_q != '1) begin
						elapsed_d = elapsed_q + 24'd1;
					end
				end else begin
					forced_d = 1'b1;
				end
				if (lowest_d >= {1'b0, bat}) begin
					lowest_d = {1'b0, bat};
				end
				drive_d = DRIVE_PWM;
				if (lowest_d >= {1'b0, cfg.slow_full_level} &&
					lowest_d >= {1'b0, cfg.mid_level} &&
					lowest_d < {1'b0, cfg.low_level}) begin
					duty_d = DUTY_HIGH;
				end else begin
					duty_d = DUTY_LOW;
				end
			end
		end else begin
			slow_cnt_d = '0;
			fast_cnt_d = '0;
			elapsed_d  = '0;
			cutoff_d   = 1'b0;
			full_d     = 1'b0;
			forced_d   = 1'b0;
		end

		res.charging   = charging_d;
		res.full_res   = full_d || forced_d;
		res.drive      = drive_d;
		res.duty       = duty_d;
		res.work_event = event_d;
		res.leds_off   = leds_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unplug_cnt_q  <= '0;
			plug_cnt_q    <= '0;
			unplug_done_q <= 1'b0;
			plug_done_q   <= 1'b0;
			charging_q    <= 1'b0;
			full_q        <= 1'b0;
			forced_q      <= 1'b0;
			cutoff_q      <= 1'b0;
			slow_cnt_q    <= '0;
			fast_cnt_q    <= '0;
			elapsed_q     <= '0;
			lowest_q      <= '0;
			drive_q       <= DRIVE_RELEASED;
			duty_q        <= '0;
		end else if (step) begin
			unplug_cnt_q  <= unplug_cnt_d;
			plug_cnt_q    <= plug_cnt_d;
			unplug_done_q <= unplug_done_d;
			plug_done_q   <= plug_done_d;
			charging_q    <= charging_d;
			full_q        <= full_d;
			forced_q      <= forced_d;
			cutoff_q      <= cutoff_d;
			slow_cnt_q    <= slow_cnt_d;
			fast_cnt_q    <= fast_cnt_d;
			elapsed_q     <= elapsed_d;
			lowest_q      <= lowest_d;
			drive_q       <= drive_d;
			duty_q        <= duty_d;
		end
	end

endmodule

`default_nettype wire
